// ===== sv/vigenere_stream_cipher_assert.svh =====
// ----------------------------------------------------------------------------
// vigenere_stream_cipher_assert.svh
// Assertion macros shared by the cipher RTL; define ASSERT_OFF to drop them.
// ----------------------------------------------------------------------------
`ifndef VIGENERE_STREAM_CIPHER_ASSERT_SVH
`define VIGENERE_STREAM_CIPHER_ASSERT_SVH

`ifndef ASSERT_OFF

// Check a property on every clock edge outside reset.
`define VSC_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define VSC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define VSC_ASSERT(lbl, clk, rst, prop, msg)
`define VSC_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// ===== sv/vsc_pkg.sv =====
// ----------------------------------------------------------------------------
// vsc_pkg
// Types, constants and symbol mapping for the Vigenere stream cipher.
// ----------------------------------------------------------------------------
package vsc_pkg;

   localparam int SYM_W       = 5;
   localparam int BYTE_W      = 8;
   localparam int SLOT_W      = 7;
   localparam int MOD_W       = 7;
   localparam int LEN_W       = 8;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 8;
   localparam int REQ_TDATA_W = 24;
   localparam int REQ_TUSER_W = 1;
   localparam int RSP_TDATA_W = 8;
   localparam int LEN_MAX     = 128;

   localparam logic [SYM_W-1:0]  SYM_SPACE = 5'd26;
   localparam logic [MOD_W-1:0]  MOD_MIN   = 7'd27;
   localparam logic [MOD_W-1:0]  MOD_MAX   = 7'd64;
   localparam logic [LEN_W-1:0]  LEN_RESET = 8'd1;

   localparam logic [BYTE_W-1:0] ASCII_LF      = 8'd10;
   localparam logic [BYTE_W-1:0] ASCII_SPACE   = 8'd32;
   localparam logic [BYTE_W-1:0] ASCII_UPPER_A = 8'd65;
   localparam logic [BYTE_W-1:0] ASCII_UPPER_Z = 8'd90;
   localparam logic [BYTE_W-1:0] ASCII_LOWER_A = 8'd97;
   localparam logic [BYTE_W-1:0] ASCII_LOWER_Z = 8'd122;
   localparam logic [BYTE_W-1:0] CASE_BIT      = 8'd32;
   localparam logic [BYTE_W-1:0] OUT_OFFSET    = 8'd65;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DECRYPT_MODE = 2'd0,
      CSR_MODULUS      = 2'd1,
      CSR_KEY_LENGTH   = 2'd2
   } csr_index_type;

   typedef enum logic {
      ACT_LOAD    = 1'b0,
      ACT_PROCESS = 1'b1
   } action_type;

   typedef struct packed {
      logic             valid;
      logic [SYM_W-1:0] sym;
   } sym_result_type;

   // Map a raw byte to a cipher symbol; invalid bytes come back with valid low.
   function automatic sym_result_type byte_to_symbol(input logic [BYTE_W-1:0] b);
      sym_result_type    r;
      logic [BYTE_W-1:0] folded;
      logic [BYTE_W-1:0] diff;
      r.valid = 1'b0;
      r.sym   = SYM_SPACE;
      folded  = b;
      diff    = '0;
      if (b == ASCII_LF || b == ASCII_SPACE) begin
         r.valid = 1'b1;
      end else begin
         if (b >= ASCII_UPPER_A && b <= ASCII_UPPER_Z) begin
            folded = b | CASE_BIT;
         end
         if (folded >= ASCII_LOWER_A && folded <= ASCII_LOWER_Z) begin
            diff    = folded - ASCII_LOWER_A;
            r.valid = 1'b1;
            r.sym   = diff[SYM_W-1:0];
         end
      end
      return r;
   endfunction

   // Space for the space symbol, else the value offset from upper-case A.
   function automatic logic [BYTE_W-1:0] symbol_to_ascii(input logic [MOD_W-1:0] v);
      logic [BYTE_W-1:0] r;
      if (v == MOD_W'(SYM_SPACE)) begin
         r = ASCII_SPACE;
      end else begin
         r = BYTE_W'(v) + OUT_OFFSET;
      end
      return r;
   endfunction

endpackage

// ===== sv/vigenere_stream_cipher.sv =====
// ----------------------------------------------------------------------------
// vigenere_stream_cipher - Vigenere cipher over a-z plus space, one byte a cycle unless rsp_tready stalls
// An accepted byte passes through the stage 1 registers and then the result register to rsp_tdata.
// Throughput: 1 transaction per cycle while the result channel is not stalled by rsp_tready.
// Reset: synchronous; position 0, encrypt, modulus 27, key length 1; key store not cleared
// ----------------------------------------------------------------------------
`include "vigenere_stream_cipher_assert.svh"

module vigenere_stream_cipher #(
   parameter int KEY_DEPTH = 128
) (
   input  logic                              clock,
   input  logic                              reset,
   // Input channel.
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [6:0] key_slot, [11:7] key_symbol, [19:12] data_byte, [23:20] zero
   input  logic [vsc_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // [0] action
   input  logic [vsc_pkg::REQ_TUSER_W-1:0]   req_tuser,
   // Result channel.
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [7:0] out_byte
   output logic [vsc_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   // Configuration write port.
   input  logic                              csr_we,
   input  logic [vsc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [vsc_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   import vsc_pkg::*;

   // The key store is never cleared: entries hold garbage until loaded.
   // Key length is capped by the store depth as well as by the fixed maximum.
   localparam int LEN_LIM = (KEY_DEPTH < LEN_MAX) ? KEY_DEPTH : LEN_MAX;
   localparam int POS_W   = (LEN_LIM > 1) ? $clog2(LEN_LIM) : 1;
   localparam int ADDR_W  = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
   localparam logic [LEN_W-1:0] LEN_LIM_V = LEN_W'(LEN_LIM);

   // ------------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------------
   logic             decrypt_ff, decrypt_in;
   logic [MOD_W-1:0] modulus_ff, modulus_in;
   logic [LEN_W-1:0] key_length_ff, key_length_in;

   always_comb begin
      decrypt_in    = decrypt_ff;
      modulus_in    = modulus_ff;
      key_length_in = key_length_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_DECRYPT_MODE: begin
               decrypt_in = csr_wdata[0];
            end
            CSR_MODULUS: begin
               // Clamp so that a single correction always brings a sum in range.
               modulus_in = csr_wdata[MOD_W-1:0];
               if (csr_wdata[MOD_W-1:0] < MOD_MIN) begin
                  modulus_in = MOD_MIN;
               end else if (csr_wdata[MOD_W-1:0] > MOD_MAX) begin
                  modulus_in = MOD_MAX;
               end
            end
            CSR_KEY_LENGTH: begin
               key_length_in = csr_wdata[LEN_W-1:0];
               if (csr_wdata[LEN_W-1:0] == '0) begin
                  key_length_in = LEN_RESET;
               end else if (csr_wdata[LEN_W-1:0] > LEN_LIM_V) begin
                  key_length_in = LEN_LIM_V;
               end
            end
            default: begin
               // Writes to unused indexes are dropped.
            end
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // Input decode and handshake
   // ------------------------------------------------------------------------
   logic              act_process;
   logic [SLOT_W-1:0] in_slot;
   logic [SYM_W-1:0]  in_ksym;
   logic [SYM_W-1:0]  in_ksym_sat;
   logic [BYTE_W-1:0] in_byte;
   sym_result_type    in_sym;

   assign act_process = (req_tuser[0] == ACT_PROCESS);
   assign in_slot     = req_tdata[SLOT_W-1:0];
   assign in_ksym     = req_tdata[SLOT_W+SYM_W-1:SLOT_W];
   assign in_byte     = req_tdata[SLOT_W+SYM_W+BYTE_W-1:SLOT_W+SYM_W];
   assign in_sym      = byte_to_symbol(in_byte);
   assign in_ksym_sat = (in_ksym > SYM_SPACE) ? SYM_SPACE : in_ksym;

   // Stage 1 holds a mapped symbol and its key; stage 2 is the result register.
   logic s1_valid_ff, s1_valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic s2_free;
   logic s1_move;
   logic accept;
   logic take_byte;
   logic load_key;

   assign s2_free    = !rsp_valid_ff || rsp_tready;
   assign s1_move    = s1_valid_ff && s2_free;
   assign req_tready = !s1_valid_ff || s2_free;
   assign accept     = req_tvalid && req_tready;
   // Only letters, space and newline occupy the pipeline; anything else drops.
   assign take_byte  = accept && act_process && in_sym.valid;

   // ------------------------------------------------------------------------
   // Key store and key position
   // ------------------------------------------------------------------------
   logic [ADDR_W+SLOT_W-1:0] slot_ext;
   logic [ADDR_W-1:0]        wr_addr;
   logic [ADDR_W-1:0]        rd_addr;
   logic [POS_W-1:0]         key_pos_ff, key_pos_in;
   logic [LEN_W:0]           pos_inc;

   assign slot_ext = (ADDR_W+SLOT_W)'(in_slot);
   assign wr_addr  = slot_ext[ADDR_W-1:0];
   // Loads beyond the store are ignored.
   assign load_key = accept && !act_process
                     && (slot_ext < (ADDR_W+SLOT_W)'(KEY_DEPTH));
   assign rd_addr  = ADDR_W'(key_pos_ff);
   assign pos_inc  = (LEN_W+1)'(key_pos_ff) + (LEN_W+1)'(1);

   always_comb begin
      key_pos_in = key_pos_ff;
      if (take_byte) begin
         // Wrap when reaching or passing the length, even if it was lowered.
         if (pos_inc >= (LEN_W+1)'(key_length_ff)) begin
            key_pos_in = '0;
         end else begin
            key_pos_in = pos_inc[POS_W-1:0];
         end
      end
   end

   logic [SYM_W-1:0] key_mem [KEY_DEPTH];
   logic [SYM_W-1:0] key_rd_ff;

   // Read at acceptance: every earlier load has already landed, so no bypass.
   always_ff @(posedge clock) begin
      if (load_key) begin
         key_mem[wr_addr] <= in_ksym_sat;
      end
   end

   always_ff @(posedge clock) begin
      if (take_byte) begin
         key_rd_ff <= key_mem[rd_addr];
      end
   end

   // ------------------------------------------------------------------------
   // Stage 1 payload and valid
   // ------------------------------------------------------------------------
   logic [SYM_W-1:0] s1_sym_ff, s1_sym_in;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (s1_move) begin
         s1_valid_in = 1'b0;
      end
      if (take_byte) begin
         s1_valid_in = 1'b1;
      end
      s1_sym_in = take_byte ? in_sym.sym : s1_sym_ff;
   end

   // ------------------------------------------------------------------------
   // Add or subtract the key modulo the modulus, then map back to ASCII
   // ------------------------------------------------------------------------
   logic [MOD_W-1:0]  sym_x, key_x;
   logic [MOD_W-1:0]  sum_raw;
   logic [MOD_W-1:0]  cipher_val;
   logic [BYTE_W-1:0] rsp_data_ff, rsp_data_in;

   assign sym_x = MOD_W'(s1_sym_ff);
   assign key_x = MOD_W'(key_rd_ff);

   always_comb begin
      sum_raw    = sym_x + key_x;
      cipher_val = sum_raw;
      if (!decrypt_ff) begin
         if (sum_raw >= modulus_ff) begin
            cipher_val = sum_raw - modulus_ff;
         end
      end else begin
         if (sym_x >= key_x) begin
            cipher_val = sym_x - key_x;
         end else begin
            cipher_val = sym_x + modulus_ff - key_x;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (s1_move) begin
         rsp_valid_in = 1'b1;
      end
      rsp_data_in = s1_move ? symbol_to_ascii(cipher_val) : rsp_data_ff;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // ------------------------------------------------------------------------
   // Registers
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         decrypt_ff    <= 1'b0;
         modulus_ff    <= MOD_MIN;
         key_length_ff <= LEN_RESET;
         key_pos_ff    <= '0;
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         decrypt_ff    <= decrypt_in;
         modulus_ff    <= modulus_in;
         key_length_ff <= key_length_in;
         key_pos_ff    <= key_pos_in;
         s1_valid_ff   <= s1_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload holds no reset.
   always_ff @(posedge clock) begin
      s1_sym_ff   <= s1_sym_in;
      rsp_data_ff <= rsp_data_in;
   end

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------
   `VSC_ASSERT_ALWAYS(a_reset_clears_rsp, clock, reset |=> !rsp_tvalid, "rsp valid after reset")
   `VSC_ASSERT(a_full_blocks_input, clock, reset, s1_valid_ff && rsp_valid_ff && !rsp_tready |-> !req_tready, "input taken while pipeline full")
   `VSC_ASSERT(a_stage1_advances, clock, reset, s1_valid_ff && s2_free |=> rsp_tvalid, "stage 1 item lost on advance")
   `VSC_ASSERT(a_pos_holds, clock, reset, !take_byte |=> $stable(key_pos_ff), "key position moved without a valid byte")
   `VSC_ASSERT(a_pos_in_range, clock, reset, (LEN_W+1)'(key_pos_ff) < (LEN_W+1)'(LEN_LIM), "key position beyond key store")

endmodule
